FILE: design/fps_pkg.sv
// Shared types, widths and constants of the face position smoother.
`default_nettype none

package fps_pkg;

  // Field and state widths.
  localparam int CoordBits    = 12;
  localparam int SizeBits     = 13;
  localparam int PosBits      = 14;
  localparam int AreaBits     = 25;
  localparam int AreaStepBits = 26;
  localparam int OutBits      = 16;
  localparam int HalfBits     = SizeBits - 1;

  // Stream payload widths.
  localparam int InDataBits  = 4 * CoordBits;
  localparam int OutDataBits = 3 * OutBits;

  // Configuration register map.
  localparam int CfgIdxBits = 1;
  typedef enum logic [CfgIdxBits-1:0] {
    CFG_SENSOR_WIDTH  = 1'b0,
    CFG_SENSOR_HEIGHT = 1'b1
  } cfg_reg_e;

  localparam logic [SizeBits-1:0] SensorWidthReset  = 13'd640;
  localparam logic [SizeBits-1:0] SensorHeightReset = 13'd480;

  // Queue between the front and the back.
  localparam int QueueDepth = 2;
  localparam int QPtrBits   = $clog2(QueueDepth);
  localparam int QCntBits   = $clog2(QueueDepth + 1);

  // One smoothed position handed from the front to the back.
  typedef struct packed {
    logic signed [PosBits-1:0] center_x;
    logic signed [PosBits-1:0] center_y;
    logic [AreaBits-1:0]       area;
  } fps_entry_t;

  // Control of one normalizing divider.
  typedef struct packed {
    logic load;
    logic step;
  } norm_ctrl_t;

  // Back end sequencer.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SQRT,
    BK_OUT
  } back_state_e;

  localparam int NormIters    = 15;
  localparam int AreaDivIters = 33;
  localparam int SqrtIters    = 17;
  localparam int CntBits      = $clog2(AreaDivIters);

  // The distance numerator is (2 * 100.0 in Q.14)^2 = 10000 * 2^30. Its low
  // 33 bits are zero, so the area division starts from its upper part, 1250.
  localparam logic [AreaBits-1:0] DivRemInit = 25'd1250;
  localparam logic [AreaBits-1:0] SmallArea  = 25'd1250;

  localparam logic [OutBits-1:0] Q14One  = 16'd16384;
  localparam logic [OutBits-1:0] DistMin = 16'd4915;
  localparam logic [OutBits:0]   DistMax = 17'd32768;

endpackage

`default_nettype wire

FILE: design/fps_queue.sv
// Two-entry queue that carries smoothed positions from the front to the back.
`default_nettype none

module fps_queue (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  fps_pkg::fps_entry_t data_i,
  input  wire                 pop_i,
  output fps_pkg::fps_entry_t data_o,
  output logic                full_o,
  output logic                empty_o
);

  fps_pkg::fps_entry_t                 mem_q [fps_pkg::QueueDepth];
  logic [fps_pkg::QPtrBits-1:0]        wr_ptr_q, wr_ptr_d;
  logic [fps_pkg::QPtrBits-1:0]        rd_ptr_q, rd_ptr_d;
  logic [fps_pkg::QCntBits-1:0]        count_q, count_d;

  assign full_o  = (count_q == fps_pkg::QCntBits'(fps_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == fps_pkg::QPtrBits'(fps_pkg::QueueDepth - 1)) ? '0
                 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == fps_pkg::QPtrBits'(fps_pkg::QueueDepth - 1)) ? '0
                 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: design/fps_front.sv
// Front end: takes detections and updates the smoothed center and area.
`default_nettype none

module fps_front (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  input  wire                                in_found_i,
  input  wire [fps_pkg::InDataBits-1:0]      in_data_i,
  output logic                               in_ready_o,
  input  wire                                q_full_i,
  output logic                               push_o,
  output fps_pkg::fps_entry_t                entry_o
);

  localparam int CB = fps_pkg::CoordBits;
  localparam int PB = fps_pkg::PosBits;
  localparam int AB = fps_pkg::AreaBits;
  localparam int SB = fps_pkg::AreaStepBits;
  localparam int WB = PB + 2;   // working width of the center steps
  localparam int VB = AB + 2;   // working width of the area steps

  logic signed [PB-1:0] center_x_q, center_x_d;
  logic signed [PB-1:0] center_y_q, center_y_d;
  logic signed [PB-1:0] step_x_q, step_x_d;
  logic signed [PB-1:0] step_y_q, step_y_d;
  logic [AB-1:0]        area_q, area_d;
  logic signed [SB-1:0] astep_q, astep_d;

  logic [CB-1:0]         left, top, fw, fh;
  logic [CB:0]           tgt_x, tgt_y;
  logic signed [WB-1:0]  src_x, src_y, half_x, half_y;
  logic [2*CB-1:0]       prod;
  logic signed [VB-1:0]  src_a, adj_a, quart_a, area_sum;
  logic                  accept;

  // Halving that truncates toward zero.
  function automatic logic signed [WB-1:0] trunc_half(input logic signed [WB-1:0] v);
    logic signed [WB-1:0] adj;
    adj = v + $signed({{(WB-1){1'b0}}, v[WB-1]});
    return adj >>> 1;
  endfunction

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;

  assign left = in_data_i[CB-1:0];
  assign top  = in_data_i[2*CB-1:CB];
  assign fw   = in_data_i[3*CB-1:2*CB];
  assign fh   = in_data_i[4*CB-1:3*CB];

  // New center steps: toward the face center, or decay of the held step.
  always_comb begin
    tgt_x = {1'b0, left} + {2'b0, fw[CB-1:1]};
    tgt_y = {1'b0, top} + {2'b0, fh[CB-1:1]};
    if (in_found_i) begin
      src_x = $signed({{(WB-CB-1){1'b0}}, tgt_x}) - WB'(center_x_q);
      src_y = $signed({{(WB-CB-1){1'b0}}, tgt_y}) - WB'(center_y_q);
    end else begin
      src_x = WB'(step_x_q);
      src_y = WB'(step_y_q);
    end
    half_x     = trunc_half(src_x);
    half_y     = trunc_half(src_y);
    step_x_d   = half_x[PB-1:0];
    step_y_d   = half_y[PB-1:0];
    center_x_d = center_x_q + step_x_d;
    center_y_d = center_y_q + step_y_d;
  end

  // New area step, a quarter that truncates toward zero, and the area floor.
  always_comb begin
    prod = fw * fh;
    if (in_found_i) begin
      src_a = $signed({{(VB-2*CB){1'b0}}, prod}) - $signed({2'b0, area_q});
    end else begin
      src_a = VB'(astep_q);
    end
    adj_a    = src_a + $signed({{(VB-2){1'b0}}, {2{src_a[VB-1]}}});
    quart_a  = adj_a >>> 2;
    astep_d  = quart_a[SB-1:0];
    area_sum = $signed({2'b0, area_q}) + VB'(astep_d);
    if (area_sum < $signed(VB'(1))) begin
      area_d = AB'(1);
    end else begin
      area_d = area_sum[AB-1:0];
    end
  end

  assign entry_o.center_x = center_x_d;
  assign entry_o.center_y = center_y_d;
  assign entry_o.area     = area_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      step_x_q   <= '0;
      step_y_q   <= '0;
      area_q     <= '0;
      astep_q    <= '0;
    end else if (accept) begin
      center_x_q <= center_x_d;
      center_y_q <= center_y_d;
      step_x_q   <= step_x_d;
      step_y_q   <= step_y_d;
      area_q     <= area_d;
      astep_q    <= astep_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/fps_norm_div.sv
// Bit-serial rounding divider that turns a center position into Q1.14.
`default_nettype none

module fps_norm_div (
  input  wire                                  clk_i,
  input  fps_pkg::norm_ctrl_t                  ctrl_i,
  input  wire signed [fps_pkg::PosBits-1:0]    pos_i,
  input  wire [fps_pkg::SizeBits-1:0]          size_i,
  output logic signed [fps_pkg::OutBits-1:0]   norm_o
);

  localparam int HB = fps_pkg::HalfBits;
  localparam int PB = fps_pkg::PosBits;
  localparam int DB = PB + 2;
  localparam int QB = fps_pkg::NormIters;
  localparam int OB = fps_pkg::OutBits;

  logic [HB-1:0]        half_raw, half_eff;
  logic signed [DB-1:0] diff;
  logic [DB-1:0]        mag;
  logic                 sat;

  logic [HB:0]   rem_q, rem_d;
  logic [HB:0]   div_q;
  logic [QB-1:0] quot_q, quot_d;
  logic [QB-1:0] shf_q;
  logic          neg_q, sat_q;
  logic [HB+1:0] rem2;
  logic          ge;
  logic [OB-1:0] mag_out;

  // Half size (at least 1) and the offset of the position from it.
  always_comb begin
    half_raw = size_i[HB:1];
    half_eff = (half_raw == '0) ? HB'(1) : half_raw;
    diff     = $signed({{(DB-HB){1'b0}}, half_eff}) - DB'(pos_i);
    mag      = diff[DB-1] ? DB'(-diff) : DB'(diff);
    sat      = (mag >= {{(DB-HB){1'b0}}, half_eff});
  end

  // One quotient bit per step: the dividend is mag * 2^15 + half over 2 * half.
  always_comb begin
    rem2   = {rem_q, shf_q[QB-1]};
    ge     = (rem2 >= {1'b0, div_q});
    rem_d  = ge ? (rem2[HB:0] - div_q) : rem2[HB:0];
    quot_d = {quot_q[QB-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      rem_q  <= {1'b0, mag[HB-1:0]};
      div_q  <= {half_eff, 1'b0};
      shf_q  <= {{(QB-HB){1'b0}}, half_eff};
      quot_q <= '0;
      neg_q  <= diff[DB-1];
      sat_q  <= sat;
    end else if (ctrl_i.step) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
      shf_q  <= {shf_q[QB-2:0], 1'b0};
    end
  end

  // Saturation and sign.
  always_comb begin
    mag_out = sat_q ? fps_pkg::Q14One : {{(OB-QB){1'b0}}, quot_q};
    norm_o  = neg_q ? $signed(-mag_out) : $signed(mag_out);
  end

endmodule

`default_nettype wire

FILE: design/fps_back.sv
// Back end: normalizes the center and derives the distance, one entry at a time.
`default_nettype none

module fps_back (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  fps_pkg::fps_entry_t                entry_i,
  input  wire                                q_empty_i,
  output logic                               q_pop_o,
  input  wire [fps_pkg::SizeBits-1:0]        sensor_width_i,
  input  wire [fps_pkg::SizeBits-1:0]        sensor_height_i,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic [fps_pkg::OutDataBits-1:0]    out_data_o
);

  localparam int AB = fps_pkg::AreaBits;
  localparam int QB = fps_pkg::AreaDivIters;
  localparam int RB = fps_pkg::SqrtIters;
  localparam int SB = RB + 2;
  localparam int OB = fps_pkg::OutBits;
  localparam int NB = fps_pkg::CntBits;
  localparam int OutDataBits_l = fps_pkg::OutDataBits;

  fps_pkg::back_state_e state_q, state_d;
  logic [NB-1:0]        cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;

  logic [AB-1:0]        area_q, area_d;
  logic                 small_q, small_d;
  logic [AB-1:0]        rem_q, rem_d;
  logic [QB-1:0]        quot_q, quot_d;
  logic [QB:0]          rad_q, rad_d;
  logic [SB-1:0]        srem_q, srem_d;
  logic [RB-1:0]        root_q, root_d;
  logic [OutDataBits_l-1:0] out_data_q, out_data_d;

  fps_pkg::norm_ctrl_t       norm_ctrl;
  logic signed [OB-1:0]      norm_x, norm_y;

  logic [AB:0]   rem2;
  logic          dge;
  logic [AB:0]   drem;
  logic [QB-1:0] quot_nx;
  logic [SB+1:0] remw, trial, sdiff;
  logic          sge;
  logic [RB:0]   root_inc;
  logic [RB-1:0] qd;
  logic [OB-1:0] dist_q14;

  // Normalizing dividers for both axes.
  fps_norm_div u_norm_x (
    .clk_i  (clk_i),
    .ctrl_i (norm_ctrl),
    .pos_i  (entry_i.center_x),
    .size_i (sensor_width_i),
    .norm_o (norm_x)
  );

  fps_norm_div u_norm_y (
    .clk_i  (clk_i),
    .ctrl_i (norm_ctrl),
    .pos_i  (entry_i.center_y),
    .size_i (sensor_height_i),
    .norm_o (norm_y)
  );

  // One step of the restoring division 10000 * 2^30 / area.
  always_comb begin
    rem2    = {rem_q, 1'b0};
    dge     = (rem2 >= {1'b0, area_q});
    drem    = dge ? (rem2 - {1'b0, area_q}) : rem2;
    quot_nx = {quot_q[QB-2:0], dge};
  end

  // One step of the digit-by-digit square root of the quotient.
  always_comb begin
    remw  = {srem_q, rad_q[QB:QB-1]};
    trial = {2'b0, root_q, 2'b01};
    sge   = (remw >= trial);
    sdiff = remw - trial;
  end

  // Distance: the largest q with 2q - 1 <= square root, then the limits.
  always_comb begin
    root_inc = {1'b0, root_q} + 1'b1;
    qd       = root_inc[RB:1];
    if (small_q || (qd >= fps_pkg::DistMax)) begin
      dist_q14 = fps_pkg::DistMax[OB-1:0];
    end else if (qd < {{(RB-OB){1'b0}}, fps_pkg::DistMin}) begin
      dist_q14 = fps_pkg::DistMin;
    end else begin
      dist_q14 = qd[OB-1:0];
    end
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    area_d      = area_q;
    small_d     = small_q;
    rem_d       = rem_q;
    quot_d      = quot_q;
    rad_d       = rad_q;
    srem_d      = srem_q;
    root_d      = root_q;
    q_pop_o     = 1'b0;
    norm_ctrl   = '0;
    case (state_q)
      fps_pkg::BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o        = 1'b1;
          norm_ctrl.load = 1'b1;
          area_d         = entry_i.area;
          small_d        = (entry_i.area <= fps_pkg::SmallArea);
          rem_d          = fps_pkg::DivRemInit;
          quot_d         = '0;
          cnt_d          = '0;
          state_d        = fps_pkg::BK_DIV;
        end
      end
      fps_pkg::BK_DIV: begin
        norm_ctrl.step = (cnt_q < NB'(fps_pkg::NormIters));
        rem_d          = drem[AB-1:0];
        quot_d         = quot_nx;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == NB'(QB - 1)) begin
          rad_d   = {1'b0, quot_nx};
          srem_d  = '0;
          root_d  = '0;
          cnt_d   = '0;
          state_d = fps_pkg::BK_SQRT;
        end
      end
      fps_pkg::BK_SQRT: begin
        rad_d  = {rad_q[QB-2:0], 2'b00};
        srem_d = sge ? sdiff[SB-1:0] : remw[SB-1:0];
        root_d = {root_q[RB-2:0], sge};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == NB'(RB - 1)) begin
          cnt_d   = '0;
          state_d = fps_pkg::BK_OUT;
        end
      end
      fps_pkg::BK_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = {dist_q14, norm_y, norm_x};
          state_d     = fps_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = fps_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fps_pkg::BK_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    area_q     <= area_d;
    small_q    <= small_d;
    rem_q      <= rem_d;
    quot_q     <= quot_d;
    rad_q      <= rad_d;
    srem_q     <= srem_d;
    root_q     <= root_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

FILE: design/face_position_smoother_top.sv
// Top level of the face position smoother: configuration registers and stream ports.
//
// One result comes out for every detection taken in. The front end updates the
// smoothed center and area in the cycle a detection is accepted and hands it to a
// two-entry queue, so it keeps taking detections until the queue is full. The back
// end works on one queued entry at a time, finishing one before it takes the next:
// it takes the entry, runs a bit-serial division of the distance numerator by the
// area (the two 15-step center dividers run alongside it), then a digit-by-digit
// square root, and loads the output register once that register is free. The user
// must write sensor width and height through the configuration port only while no
// transaction is in flight; the block itself does not enforce this.
`default_nettype none

module face_position_smoother_top (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  // Configuration writes.
  input  wire                                   cfg_we_i,
  input  wire [fps_pkg::CfgIdxBits-1:0]         cfg_idx_i,
  input  wire [fps_pkg::SizeBits-1:0]           cfg_data_i,
  // Detection stream.
  input  wire                                   s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // Fields from bit 0: face_left[11:0], face_top[23:12], face_width[35:24],
  // face_height[47:36].
  input  wire [fps_pkg::InDataBits-1:0]         s_axis_tdata_i,
  // Fields: face_found[0].
  input  wire                                   s_axis_tuser_i,
  // Result stream.
  output logic                                  m_axis_tvalid_o,
  input  wire                                   m_axis_tready_i,
  // Fields from bit 0: norm_x[15:0], norm_y[31:16], distance[47:32].
  output logic [fps_pkg::OutDataBits-1:0]       m_axis_tdata_o
);

  logic [fps_pkg::SizeBits-1:0] sensor_width_q;
  logic [fps_pkg::SizeBits-1:0] sensor_height_q;

  fps_pkg::fps_entry_t push_entry;
  fps_pkg::fps_entry_t pop_entry;
  logic                push;
  logic                pop;
  logic                q_full;
  logic                q_empty;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_width_q  <= fps_pkg::SensorWidthReset;
      sensor_height_q <= fps_pkg::SensorHeightReset;
    end else if (cfg_we_i) begin
      case (fps_pkg::cfg_reg_e'(cfg_idx_i))
        fps_pkg::CFG_SENSOR_WIDTH:  sensor_width_q  <= cfg_data_i;
        fps_pkg::CFG_SENSOR_HEIGHT: sensor_height_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  fps_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_found_i (s_axis_tuser_i),
    .in_data_i  (s_axis_tdata_i),
    .in_ready_o (s_axis_tready_o),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  fps_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .pop_i   (pop),
    .data_o  (pop_entry),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  fps_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .entry_i         (pop_entry),
    .q_empty_i       (q_empty),
    .q_pop_o         (pop),
    .sensor_width_i  (sensor_width_q),
    .sensor_height_i (sensor_height_q),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .out_data_o      (m_axis_tdata_o)
  );

endmodule

`default_nettype wire
